[src/spc_pkg.sv]
// ============================================================================
// Serpent cipher package
// S-box tables, linear transforms and shared constants for the Serpent core.
// ============================================================================
package spc_pkg;

  localparam int unsigned RoundCount  = 32;
  localparam int unsigned SubkeyCount = RoundCount + 1;
  localparam int unsigned SkAw        = $clog2(SubkeyCount);
  localparam logic [31:0] Golden      = 32'h9e3779b9;

  // configuration register indexes
  localparam logic [2:0] CfgKeySize = 3'd0;
  localparam logic [2:0] CfgKey0    = 3'd1;
  localparam logic [2:0] CfgKey1    = 3'd2;
  localparam logic [2:0] CfgKey2    = 3'd3;
  localparam logic [2:0] CfgKey3    = 3'd4;

  localparam logic [1:0] KeySize128 = 2'd0;
  localparam logic [1:0] KeySize192 = 2'd1;

  typedef logic [31:0] word_t;
  typedef logic [127:0] blk_t;

  // forward S-box lookup on one nibble
  function automatic logic [3:0] sbox_fwd(input logic [2:0] sel, input logic [3:0] n);
    logic [63:0] row;
    case (sel)
      3'd0: row = {4'd12,4'd9,4'd0,4'd7,4'd2,4'd4,4'd13,4'd14,
                   4'd11,4'd5,4'd6,4'd10,4'd1,4'd15,4'd8,4'd3};
      3'd1: row = {4'd4,4'd3,4'd13,4'd6,4'd8,4'd14,4'd11,4'd1,
                   4'd10,4'd5,4'd0,4'd9,4'd7,4'd2,4'd12,4'd15};
      3'd2: row = {4'd2,4'd5,4'd11,4'd0,4'd4,4'd14,4'd1,4'd13,
                   4'd15,4'd10,4'd12,4'd3,4'd9,4'd7,4'd6,4'd8};
      3'd3: row = {4'd14,4'd5,4'd7,4'd10,4'd4,4'd2,4'd1,4'd13,
                   4'd3,4'd6,4'd9,4'd12,4'd8,4'd11,4'd15,4'd0};
      3'd4: row = {4'd13,4'd7,4'd14,4'd9,4'd10,4'd4,4'd5,4'd2,
                   4'd6,4'd11,4'd0,4'd12,4'd3,4'd8,4'd15,4'd1};
      3'd5: row = {4'd1,4'd7,4'd6,4'd13,4'd8,4'd14,4'd3,4'd0,
                   4'd12,4'd9,4'd10,4'd4,4'd11,4'd2,4'd5,4'd15};
      3'd6: row = {4'd0,4'd10,4'd3,4'd13,4'd15,4'd1,4'd9,4'd14,
                   4'd11,4'd6,4'd4,4'd8,4'd5,4'd12,4'd2,4'd7};
      default: row = {4'd6,4'd5,4'd3,4'd9,4'd10,4'd12,4'd4,4'd7,
                      4'd11,4'd2,4'd8,4'd14,4'd0,4'd15,4'd13,4'd1};
    endcase
    return row[n*4 +: 4];
  endfunction

  // inverse S-box lookup: search the forward table
  function automatic logic [3:0] sbox_inv(input logic [2:0] sel, input logic [3:0] n);
    logic [3:0] r;
    r = '0;
    for (int j = 0; j < 16; j++) begin
      if (sbox_fwd(sel, 4'(j)) == n) r = 4'(j);
    end
    return r;
  endfunction

  // bitsliced S-box layer; word 0 is the nibble LSB
  function automatic blk_t sbox_layer(input logic [2:0] sel, input logic inv, input blk_t x);
    blk_t y;
    logic [3:0] nib, o;
    y = '0;
    for (int j = 0; j < 32; j++) begin
      nib = {x[96+j], x[64+j], x[32+j], x[j]};
      o = inv ? sbox_inv(sel, nib) : sbox_fwd(sel, nib);
      y[j] = o[0]; y[32+j] = o[1]; y[64+j] = o[2]; y[96+j] = o[3];
    end
    return y;
  endfunction

  function automatic word_t rol(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic blk_t lin_fwd(input blk_t b);
    word_t x0, x1, x2, x3;
    {x3, x2, x1, x0} = b;
    x0 = rol(x0, 13); x2 = rol(x2, 3);
    x1 = x1 ^ x0 ^ x2; x3 = x3 ^ x2 ^ (x0 << 3);
    x1 = rol(x1, 1); x3 = rol(x3, 7);
    x0 = x0 ^ x1 ^ x3; x2 = x2 ^ x3 ^ (x1 << 7);
    x0 = rol(x0, 5); x2 = rol(x2, 22);
    return {x3, x2, x1, x0};
  endfunction

  function automatic blk_t lin_inv(input blk_t b);
    word_t x0, x1, x2, x3;
    {x3, x2, x1, x0} = b;
    x2 = rol(x2, 10); x0 = rol(x0, 27);
    x2 = x2 ^ x3 ^ (x1 << 7); x0 = x0 ^ x1 ^ x3;
    x3 = rol(x3, 25); x1 = rol(x1, 31);
    x3 = x3 ^ x2 ^ (x0 << 3); x1 = x1 ^ x0 ^ x2;
    x2 = rol(x2, 29); x0 = rol(x0, 19);
    return {x3, x2, x1, x0};
  endfunction

endpackage

[src/spc_ram.sv]
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, registered read data.
// ============================================================================
module spc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[src/serpent_block_cipher.sv]
// ============================================================================
// Serpent block cipher
// ECB Serpent core with on-chip key expansion into a subkey RAM.
// ============================================================================
// channel | direction | handshake           | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
// in      | in        | in_valid/in_ready   | req_type_i, data_in_low_i/high_i
// out     | out       | out_valid/out_ready | data_out_low_o/high_o
//
// A block passes from its input transfer through the one shared round unit
// (subkey read, 32 rounds, final key mixing) to out_valid; the result then
// waits for its transfer, and the core returns to idle before the next input
// transfer. After reset or any key write, the first block first runs the key
// expansion: 132 word steps, one per cycle, with an S-box on every fourth.
// in_ready is low while a block or an expansion is in flight or the result
// waits; cfg_ready is always high.
module serpent_block_cipher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         req_type_i,
  input  logic [63:0]  data_in_low_i,
  input  logic [63:0]  data_in_high_i,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  data_out_low_o,
  output logic [63:0]  data_out_high_o
);
  import spc_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExp  = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StRnd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]    st_q, st_d;
  logic [1:0]    ksize_q;
  logic [255:0]  key_q;
  logic          stale_q;
  logic [255:0]  win_q, win_d;
  logic [7:0]    wcnt_q, wcnt_d;
  blk_t          grp_q, grp_d;
  blk_t          x_q, x_d;
  logic          dec_q, dec_d;
  logic [5:0]    rcnt_q, rcnt_d;
  logic          we;
  logic [SkAw-1:0] waddr, raddr;
  blk_t          wdata, sk;
  word_t         v;
  logic [31:0]   kw [8];

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_q == StIdle);
  assign out_valid = (st_q == StOut);
  assign data_out_low_o  = x_q[63:0];
  assign data_out_high_o = x_q[127:64];

  // key registers and stale flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q <= 2'd2;
      key_q   <= '0;
      stale_q <= 1'b1;
    end else begin
      if (st_q == StExp && wcnt_q == 8'(4*SubkeyCount-1)) begin
        stale_q <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index_i)
          CfgKeySize: begin ksize_q <= cfg_data_i[1:0]; stale_q <= 1'b1; end
          CfgKey0: begin key_q[63:0] <= cfg_data_i; stale_q <= 1'b1; end
          CfgKey1: begin key_q[127:64] <= cfg_data_i; stale_q <= 1'b1; end
          CfgKey2: begin key_q[191:128] <= cfg_data_i; stale_q <= 1'b1; end
          CfgKey3: begin key_q[255:192] <= cfg_data_i; stale_q <= 1'b1; end
          default: ;
        endcase
      end
    end
  end

  // padded key words
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      kw[i] = key_q[32*i +: 32];
    end
    if (ksize_q == KeySize128) begin
      kw[4] = 32'd1; kw[5] = '0; kw[6] = '0; kw[7] = '0;
    end else if (ksize_q == KeySize192) begin
      kw[6] = 32'd1; kw[7] = '0;
    end
  end

  // one prekey word per cycle
  assign v = rol(win_q[31:0] ^ win_q[127:96] ^ win_q[191:160] ^ win_q[255:224]
                 ^ Golden ^ {24'd0, wcnt_q}, 11);

  always_comb begin
    st_d = st_q; win_d = win_q; wcnt_d = wcnt_q; grp_d = grp_q;
    x_d = x_q; dec_d = dec_q; rcnt_d = rcnt_q;
    we = 1'b0; waddr = wcnt_q[SkAw+1:2]; wdata = '0;
    raddr = '0;
    unique case (st_q)
      StIdle: begin
        if (in_valid) begin
          x_d = {data_in_high_i, data_in_low_i};
          dec_d = req_type_i;
          wcnt_d = '0;
          win_d = {kw[7], kw[6], kw[5], kw[4], kw[3], kw[2], kw[1], kw[0]};
          st_d = stale_q ? StExp : StRd;
        end
        raddr = in_valid ? (req_type_i ? SkAw'(RoundCount) : '0) : '0;
        rcnt_d = '0;
      end
      StExp: begin
        win_d = {v, win_q[255:32]};
        grp_d = {v, grp_q[127:32]};
        if (wcnt_q[1:0] == 2'd3) begin
          we = 1'b1;
          wdata = sbox_layer(3'(3 - wcnt_q[4:2]), 1'b0, {v, grp_q[127:32]});
        end
        wcnt_d = wcnt_q + 8'd1;
        raddr = dec_q ? SkAw'(RoundCount) : '0;
        if (wcnt_q == 8'(4*SubkeyCount-1)) st_d = StRd;
      end
      StRd: begin
        raddr = dec_q ? SkAw'(RoundCount) : '0;
        st_d = StRnd;
        rcnt_d = '0;
      end
      StRnd: begin
        // rcnt = step 0..32; subkey for this step is in sk
        if (!dec_q) begin
          if (rcnt_q == 6'(RoundCount)) begin
            x_d = x_q ^ sk;
          end else begin
            x_d = sbox_layer(rcnt_q[2:0], 1'b0, x_q ^ sk);
            if (rcnt_q != 6'(RoundCount-1)) x_d = lin_fwd(x_d);
          end
          raddr = SkAw'(rcnt_q + 6'd1);
        end else begin
          // step 0: mix key 32; step s>0: mix key 32-s
          if (rcnt_q == 6'd0) begin
            x_d = sbox_layer(3'd7, 1'b1, x_q ^ sk);
          end else begin
            x_d = sbox_layer(3'(6'd32 - rcnt_q - 6'd1), 1'b1, lin_inv(x_q ^ sk));
            if (rcnt_q == 6'(RoundCount)) x_d = x_q ^ sk;
          end
          raddr = SkAw'(6'(RoundCount) - rcnt_q - 6'd1);
        end
        rcnt_d = rcnt_q + 6'd1;
        if (rcnt_q == 6'(RoundCount)) st_d = StOut;
      end
      StOut: begin
        if (out_ready) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d; wcnt_q <= wcnt_d; grp_q <= grp_d;
    x_q <= x_d; dec_q <= dec_d; rcnt_q <= rcnt_d;
  end

  spc_ram #(.Width(128), .Depth(SubkeyCount)) u_sk_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(sk)
  );

  // checks
  a_exp_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StExp) |-> ($past(st_q) == StIdle || $past(st_q) == StExp)) else $error("exp");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid && $stable(x_q)) else $error("hold");
  a_no_we_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRnd) |-> !we) else $error("we");
endmodule
